FILE: rtl/core/skt_pkg.sv
// Shared types and constants of the sorted key table.
// Holds field widths, request and status codes, and the record and result structs.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package skt_pkg;

    // Field widths of the request and result channels.
    localparam int REQ_W   = 3;
    localparam int KEY_W   = 31;
    localparam int GRADE_W = 10;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;

    // Request kinds. Codes above REQ_COUNT change nothing and are answered like REQ_COUNT.
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    // One stored record.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [GRADE_W-1:0] grade;
    } t_entry;

    // One result.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [GRADE_W-1:0] grade_out;
        logic [POS_W-1:0]   position;
        logic [CNT_W-1:0]   entry_count;
    } t_rsp;

endpackage

`default_nettype wire

FILE: rtl/core/skt_if.sv
// Valid/ready channel interfaces of the sorted key table.
// skt_req_if carries requests, skt_rsp_if carries results.
// Depends on skt_pkg for the field widths.
`default_nettype none

interface skt_req_if;
    import skt_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [KEY_W-1:0]   key;
    logic [GRADE_W-1:0] grade;

    modport source (output valid, output req_type, output key, output grade, input ready);
    modport sink   (input valid, input req_type, input key, input grade, output ready);
endinterface

interface skt_rsp_if;
    import skt_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [GRADE_W-1:0] grade_out;
    logic [POS_W-1:0]   position;
    logic [CNT_W-1:0]   entry_count;

    modport source (output valid, output status, output grade_out, output position,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input grade_out, input position,
                    input entry_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sorted_key_table.sv
// Top level of the sorted key table: a CAPACITY-deep table of (key, grade) records
// kept in ascending key order in one synchronous memory. Depends on skt_pkg and on
// the channel interfaces in skt_if.sv.
//
//   Channel  | Direction | Payload                                      | Handshake
//   ---------+-----------+----------------------------------------------+-----------
//   i_req    | in        | req_type, key, grade                         | valid/ready
//   o_rsp    | out       | status, grade_out, position, entry_count     | valid/ready
//
// One request is worked on at a time. Insert, search and delete walk the memory one entry
// per cycle through its single read port (insert walks down from the top, search stops at
// the first match, delete walks to the end); clear, count, unused codes, requests on an empty
// table and inserts into a full table skip the walk. A finished result sits in an output
// register, so the next request is accepted while it waits. Reset empties the table at once;
// the memory needs no clearing. A stalled result holds the block in its final step until taken.
`default_nettype none

module sorted_key_table #(
    parameter int CAPACITY = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    skt_req_if.sink    i_req,
    skt_rsp_if.source  o_rsp
);
    import skt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // Record memory and its ports.
    t_entry          r_mem [CAPACITY];
    t_entry          r_rd_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;

    // Control state.
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_issue, n_issue;
    logic            r_pend, n_pend;
    logic            r_found, n_found;
    logic            r_out_vld, n_out_vld;

    // Request and walk payload.
    logic [REQ_W-1:0]   r_op, n_op;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [GRADE_W-1:0] r_grade, n_grade;
    logic [AW-1:0]      r_addr, n_addr;
    logic [AW-1:0]      r_paddr, n_paddr;
    logic [AW-1:0]      r_pos, n_pos;
    logic [GRADE_W-1:0] r_gout, n_gout;
    t_rsp               r_out, n_out;

    logic last_rd;
    logic key_ge;
    logic key_eq;
    logic scan_req;

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.grade_out   = r_out.grade_out;
    assign o_rsp.position    = r_out.position;
    assign o_rsp.entry_count = r_out.entry_count;

    // Memory: one write and one registered read per cycle. During a walk the write
    // address always trails the read address by two entries, so they never meet.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Next-state logic of the walk sequencer.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_issue   = r_issue;
        n_pend    = r_pend;
        n_found   = r_found;
        n_out_vld = r_out_vld;
        n_op      = r_op;
        n_key     = r_key;
        n_grade   = r_grade;
        n_addr    = r_addr;
        n_paddr   = r_paddr;
        n_pos     = r_pos;
        n_gout    = r_gout;
        n_out     = r_out;
        rd_en     = 1'b0;
        rd_addr   = r_addr;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = '{key: r_key, grade: r_grade};

        key_ge   = (r_rd_data.key >= r_key);
        key_eq   = (r_rd_data.key == r_key);
        last_rd  = (r_op == REQ_INSERT) ? (r_addr == '0)
                                        : (r_addr == AW'(r_count - CW'(1)));
        scan_req = 1'b0;

        // A waiting result leaves once the sink takes it.
        if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.req_type;
                    n_key   = i_req.key;
                    n_grade = i_req.grade;
                    n_found = 1'b0;
                    n_pend  = 1'b0;
                    n_issue = 1'b1;
                    n_gout  = '0;
                    n_pos   = AW'(r_count);
                    // Insert walks down from the top; search and delete walk up.
                    n_addr  = (i_req.req_type == REQ_INSERT) ? AW'(r_count - CW'(1)) : '0;
                    scan_req = ((i_req.req_type == REQ_INSERT) && (r_count != '0) &&
                                (r_count != CAP_CNT)) ||
                               (((i_req.req_type == REQ_SEARCH) ||
                                 (i_req.req_type == REQ_DELETE)) && (r_count != '0));
                    n_state = scan_req ? S_SCAN : S_FIN;
                end
            end

            S_SCAN: begin
                // Issue the next read while the previous one is evaluated.
                if (r_issue) begin
                    rd_en   = 1'b1;
                    n_pend  = 1'b1;
                    n_paddr = r_addr;
                    if (last_rd) begin
                        n_issue = 1'b0;
                    end else if (r_op == REQ_INSERT) begin
                        n_addr = r_addr - 1'b1;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end else begin
                    n_pend = 1'b0;
                end

                if (r_pend) begin
                    case (r_op)
                        REQ_INSERT: begin
                            // Keys not below the new key move up one place.
                            if (key_ge) begin
                                wr_en   = 1'b1;
                                wr_addr = r_paddr + 1'b1;
                                wr_data = r_rd_data;
                                n_pos   = r_paddr;
                            end else begin
                                n_issue = 1'b0;
                                n_state = S_FIN;
                            end
                        end
                        REQ_SEARCH: begin
                            if (key_eq) begin
                                n_found = 1'b1;
                                n_pos   = r_paddr;
                                n_gout  = r_rd_data.grade;
                                n_issue = 1'b0;
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                            // Delete: after the first match, every entry moves down.
                            if (r_found) begin
                                wr_en   = 1'b1;
                                wr_addr = r_paddr - 1'b1;
                                wr_data = r_rd_data;
                            end else if (key_eq) begin
                                n_found = 1'b1;
                                n_pos   = r_paddr;
                            end
                        end
                    endcase
                end else if (!r_issue) begin
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                // The new record lands in the gap; repeating the write while the
                // output waits is harmless.
                if ((r_op == REQ_INSERT) && (r_count != CAP_CNT)) begin
                    wr_en = 1'b1;
                end
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    n_out     = '{status: ST_OK, grade_out: '0, position: '0,
                                  entry_count: CNT_W'(r_count)};
                    case (r_op) inside
                        REQ_INSERT: begin
                            if (r_count == CAP_CNT) begin
                                n_out.status = ST_FULL;
                            end else begin
                                n_count              = r_count + CW'(1);
                                n_out.position       = POS_W'(r_pos);
                                n_out.entry_count    = CNT_W'(r_count + CW'(1));
                            end
                        end
                        REQ_SEARCH, REQ_DELETE: begin
                            if (r_count == '0) begin
                                n_out.status = ST_EMPTY;
                            end else if (!r_found) begin
                                n_out.status = ST_NOT_FOUND;
                            end else begin
                                n_out.position = POS_W'(r_pos);
                                if (r_op == REQ_SEARCH) begin
                                    n_out.grade_out = r_gout;
                                end else begin
                                    n_count           = r_count - CW'(1);
                                    n_out.entry_count = CNT_W'(r_count - CW'(1));
                                end
                            end
                        end
                        REQ_CLEAR: begin
                            n_count           = '0;
                            n_out.entry_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_issue   <= 1'b0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_issue   <= n_issue;
            r_pend    <= n_pend;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_key   <= n_key;
        r_grade <= n_grade;
        r_addr  <= n_addr;
        r_paddr <= n_paddr;
        r_pos   <= n_pos;
        r_gout  <= n_gout;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

FILE: rtl/core/skt_checker.sv
// Port-level checker of the sorted key table and its bind to the top level.
// Watches only the request and result handshakes and the result fields.
// Depends on skt_pkg for widths and status codes.
`default_nettype none

module skt_checker #(
    parameter int CAPACITY = 64
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_req_valid,
    input wire logic                          i_req_ready,
    input wire logic                          i_rsp_valid,
    input wire logic                          i_rsp_ready,
    input wire logic [skt_pkg::STAT_W-1:0]    i_status,
    input wire logic [skt_pkg::GRADE_W-1:0]   i_grade_out,
    input wire logic [skt_pkg::POS_W-1:0]     i_position,
    input wire logic [skt_pkg::CNT_W-1:0]     i_entry_count
);
    import skt_pkg::*;

    // A result that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("result dropped before it was taken");

    // Only one request is in work at a time.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while another is in work");

    // A full report shows a table at capacity.
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_status == ST_FULL)) |-> (i_entry_count == CNT_W'(CAPACITY)))
        else $error("full status with a count below capacity");

    // An empty report shows no records and no position or grade.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_status == ST_EMPTY)) |->
        ((i_entry_count == '0) && (i_position == '0) && (i_grade_out == '0)))
        else $error("empty status with nonzero fields");

endmodule

bind sorted_key_table skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_grade_out   (o_rsp.grade_out),
    .i_position    (o_rsp.position),
    .i_entry_count (o_rsp.entry_count)
);

`default_nettype wire

FILE: tb/tb_sorted_key_table.sv
// Self-checking testbench of the sorted key table: a directed table, then random phases.
// Results are predicted by a behavioral copy of the table, or fixed by the directed row, and checked field by field.
// Depends on skt_pkg, the channel interfaces in skt_if.sv and sorted_key_table.
`default_nettype none

module tb_sorted_key_table;
    import skt_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int CLK_PERIOD   = 10;
    localparam int MAX_GAP      = 19;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = CAPACITY + 16;

    localparam logic [KEY_W-1:0]   KEY_MAX   = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0]   KEY_HIGH  = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [GRADE_W-1:0] GRADE_MAX = {GRADE_W{1'b1}};

    // Request codes the block has no meaning for.
    localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [KEY_W-1:0]   key;
        logic [GRADE_W-1:0] grade;
    } t_request;

    typedef struct {
        t_request req;
        bit       has_fixed;
        t_rsp     fixed_rsp;
    } t_directed_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    skt_req_if req_ch ();
    skt_rsp_if rsp_ch ();

    sorted_key_table #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Behavioral copy of the table, advanced once per accepted request.
    logic [KEY_W-1:0]   model_keys   [CAPACITY];
    logic [GRADE_W-1:0] model_grades [CAPACITY];
    int                 model_count = 0;
    int                 peak_count  = 0;

    t_rsp          awaited_results [$];
    t_directed_row directed_rows   [$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int requests_by_kind [8];
    int status_seen      [4];

    // Handshake pressure controls of the sender; hold_results is also read by the receiver.
    bit hold_results = 1'b0;
    int sender_rush  = 0;
    bit sender_burst = 1'b0;

    // Applies one request to the table copy and returns the result it must produce.
    function automatic t_rsp sorted_table_update(input t_request r);
        t_rsp rsp;
        int   p;
        int   i;
        rsp = '0;
        case (r.req_type)
            REQ_INSERT: begin
                if (model_count >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    // An equal key lands ahead of the equal keys already held.
                    p = 0;
                    while (p < model_count && model_keys[p] < r.key) p++;
                    for (i = model_count; i > p; i--) begin
                        model_keys[i]   = model_keys[i-1];
                        model_grades[i] = model_grades[i-1];
                    end
                    model_keys[p]   = r.key;
                    model_grades[p] = r.grade;
                    model_count++;
                    rsp.position = p[POS_W-1:0];
                end
            end
            REQ_SEARCH, REQ_DELETE: begin
                if (model_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    p = 0;
                    while (p < model_count && model_keys[p] != r.key) p++;
                    if (p == model_count) begin
                        rsp.status = ST_NOT_FOUND;
                    end else if (r.req_type == REQ_SEARCH) begin
                        rsp.grade_out = model_grades[p];
                        rsp.position  = p[POS_W-1:0];
                    end else begin
                        for (i = p; i + 1 < model_count; i++) begin
                            model_keys[i]   = model_keys[i+1];
                            model_grades[i] = model_grades[i+1];
                        end
                        model_count--;
                        rsp.position = p[POS_W-1:0];
                    end
                end
            end
            REQ_CLEAR: begin
                model_count = 0;
            end
            default: begin
                // Count reports the fill level; the unused codes change nothing.
            end
        endcase
        if (model_count > peak_count) peak_count = model_count;
        rsp.entry_count = model_count[CNT_W-1:0];
        return rsp;
    endfunction

    // Keys are mostly held or small ones so that searches and deletes hit.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [31:0] rnd;
        int          roll;
        roll = $urandom_range(0, 9);
        rnd  = $urandom();
        if (roll < 4 && model_count > 0) begin
            return model_keys[$urandom_range(0, model_count - 1)];
        end else if (roll < 6) begin
            return KEY_W'($urandom_range(0, 15));
        end else if (roll < 7) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return KEY_MAX;
                2:       return KEY_HIGH;
                default: return KEY_MAX - 1'b1;
            endcase
        end
        return rnd[KEY_W-1:0];
    endfunction

    function automatic logic [GRADE_W-1:0] pick_grade();
        logic [31:0] rnd;
        rnd = $urandom();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return GRADE_MAX;
            default: return rnd[GRADE_W-1:0];
        endcase
    endfunction

    // A random request of any kind, weighted toward insert, search and delete.
    function automatic t_request mixed_request();
        t_request r;
        int       roll;
        roll       = $urandom_range(0, 99);
        r.key      = pick_key();
        r.grade    = pick_grade();
        if (roll < 40)      r.req_type = REQ_INSERT;
        else if (roll < 65) r.req_type = REQ_SEARCH;
        else if (roll < 88) r.req_type = REQ_DELETE;
        else if (roll < 91) r.req_type = REQ_CLEAR;
        else if (roll < 96) r.req_type = REQ_COUNT;
        else begin
            case ($urandom_range(0, 2))
                0:       r.req_type = REQ_RSVD5;
                1:       r.req_type = REQ_RSVD6;
                default: r.req_type = REQ_RSVD7;
            endcase
        end
        return r;
    endfunction

    // Offers one request after a random gap and records its result once it is taken.
    task automatic offer_request(input t_request r, input bit has_fixed = 1'b0,
                                 input t_rsp fixed_rsp = '0);
        int   gap;
        t_rsp predicted;
        if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
        if (sender_rush > 0) begin
            gap = 0;
            sender_rush--;
        end else begin
            gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r.req_type;
        req_ch.key      <= r.key;
        req_ch.grade    <= r.grade;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predicted = sorted_table_update(r);
        awaited_results.push_back(has_fixed ? fixed_rsp : predicted);
        requests_by_kind[r.req_type]++;
    endtask

    // Sender goes quiet until every outstanding result has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [GRADE_W-1:0] grade, input bit has_fixed,
                           input logic [STAT_W-1:0] stat, input logic [GRADE_W-1:0] gout,
                           input logic [POS_W-1:0] pos, input logic [CNT_W-1:0] cnt);
        t_directed_row row;
        row.req       = '{kind, key, grade};
        row.has_fixed = has_fixed;
        row.fixed_rsp = '{stat, gout, pos, cnt};
        directed_rows.push_back(row);
    endtask

    // Fills the table to the top, presses on it while full, then deletes it down to empty.
    task automatic fill_and_empty(input bit narrow_keys);
        t_request r;
        while (model_count < CAPACITY) begin
            r.req_type = REQ_INSERT;
            r.key      = narrow_keys ? KEY_W'($urandom_range(0, 7)) : pick_key();
            r.grade    = pick_grade();
            if ($urandom_range(0, 9) == 0) begin
                r = mixed_request();
                if (r.req_type == REQ_CLEAR) r.req_type = REQ_COUNT;
            end
            offer_request(r);
        end
        repeat (4) begin
            r = '{REQ_INSERT, pick_key(), pick_grade()};
            offer_request(r);
        end
        repeat (12) begin
            r = '{REQ_SEARCH, pick_key(), pick_grade()};
            offer_request(r);
        end
        while (model_count > 0) begin
            if ($urandom_range(0, 7) == 0) begin
                r = '{($urandom_range(0, 1) == 0) ? REQ_SEARCH : REQ_DELETE,
                      pick_key(), pick_grade()};
            end else begin
                r = '{REQ_DELETE, model_keys[$urandom_range(0, model_count - 1)],
                      pick_grade()};
            end
            offer_request(r);
        end
        r = '{REQ_SEARCH, pick_key(), pick_grade()};
        offer_request(r);
        r = '{REQ_DELETE, pick_key(), pick_grade()};
        offer_request(r);
    endtask

    task automatic mixed_phase(input int count, input int hold_at, input int pause_at);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) begin
                hold_results = 1'b1;
                sender_rush  = 16;
            end
            if (n == pause_at) wait_for_results();
            offer_request(mixed_request());
        end
    endtask

    // Stimulus: reset, the directed table, then the random phases.
    initial begin : stimulus
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_COUNT;
        req_ch.key      = '0;
        req_ch.grade    = '0;

        add_row(REQ_COUNT,  '0,            '0,        1, ST_OK,    '0, 6'd0, 7'd0);
        add_row(REQ_SEARCH, '0,            '0,        1, ST_EMPTY, '0, 6'd0, 7'd0);
        add_row(REQ_DELETE, KEY_MAX,       '0,        1, ST_EMPTY, '0, 6'd0, 7'd0);
        add_row(REQ_INSERT, '0,            '0,        1, ST_OK,    '0, 6'd0, 7'd1);
        add_row(REQ_INSERT, KEY_MAX,       GRADE_MAX, 1, ST_OK,    '0, 6'd1, 7'd2);
        add_row(REQ_INSERT, 31'd5,         10'h2AA,   0, ST_OK,    '0, '0,   '0);
        add_row(REQ_INSERT, 31'd5,         10'h155,   0, ST_OK,    '0, '0,   '0);
        add_row(REQ_INSERT, 31'h2AAAAAAA,  10'h155,   0, ST_OK,    '0, '0,   '0);
        add_row(REQ_INSERT, 31'h55555555,  10'h2AA,   0, ST_OK,    '0, '0,   '0);
        add_row(REQ_SEARCH, 31'd5,         '0,        0, ST_OK,    '0, '0,   '0);
        add_row(REQ_SEARCH, KEY_MAX,       GRADE_MAX, 0, ST_OK,    '0, '0,   '0);
        add_row(REQ_SEARCH, '0,            '0,        0, ST_OK,    '0, '0,   '0);
        add_row(REQ_SEARCH, 31'd6,         '0,        0, ST_OK,    '0, '0,   '0);
        add_row(REQ_DELETE, 31'd5,         '0,        0, ST_OK,    '0, '0,   '0);
        add_row(REQ_SEARCH, 31'd5,         '0,        0, ST_OK,    '0, '0,   '0);
        add_row(REQ_DELETE, 31'd77,        '0,        0, ST_OK,    '0, '0,   '0);
        add_row(REQ_RSVD5,  KEY_MAX,       GRADE_MAX, 0, ST_OK,    '0, '0,   '0);
        add_row(REQ_RSVD6,  31'd5,         10'h155,   0, ST_OK,    '0, '0,   '0);
        add_row(REQ_RSVD7,  '0,            '0,        0, ST_OK,    '0, '0,   '0);
        add_row(REQ_COUNT,  31'h55555555,  10'h2AA,   0, ST_OK,    '0, '0,   '0);
        add_row(REQ_DELETE, KEY_MAX,       '0,        0, ST_OK,    '0, '0,   '0);
        add_row(REQ_CLEAR,  '0,            '0,        1, ST_OK,    '0, 6'd0, 7'd0);
        add_row(REQ_SEARCH, 31'd1,         '0,        1, ST_EMPTY, '0, 6'd0, 7'd0);
        add_row(REQ_DELETE, '0,            '0,        1, ST_EMPTY, '0, 6'd0, 7'd0);
        add_row(REQ_INSERT, 31'd3,         10'd1,     1, ST_OK,    '0, 6'd0, 7'd1);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].req, directed_rows[i].has_fixed,
                          directed_rows[i].fixed_rsp);
        end
        wait_for_results();

        // Mixed traffic with a long result stall and a full pause in the middle.
        mixed_phase(250, 100, 180);
        wait_for_results();

        // Two full sweeps, the second with heavily repeated keys.
        fill_and_empty(1'b0);
        fill_and_empty(1'b1);
        wait_for_results();

        mixed_phase(200, 60, 130);
        wait_for_results();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d insert, %0d search, %0d delete, %0d clear, %0d count, %0d unused.",
                 requests_by_kind[REQ_INSERT], requests_by_kind[REQ_SEARCH],
                 requests_by_kind[REQ_DELETE], requests_by_kind[REQ_CLEAR],
                 requests_by_kind[REQ_COUNT],
                 requests_by_kind[REQ_RSVD5] + requests_by_kind[REQ_RSVD6]
                 + requests_by_kind[REQ_RSVD7]);
        $display("Checked %0d results (ok %0d, not found %0d, full %0d, empty %0d), peak %0d.",
                 results_checked, status_seen[ST_OK], status_seen[ST_NOT_FOUND],
                 status_seen[ST_FULL], status_seen[ST_EMPTY], peak_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Result side: random stalls, one long hold-off on request, and the field checks.
    initial begin : result_checker
        int   stall;
        bit   recv_burst;
        t_rsp got;
        t_rsp want;
        rsp_ch.ready = 1'b0;
        recv_burst   = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            if (hold_results) begin
                hold_results = 1'b0;
                stall        = HOLD_CYCLES;
            end else begin
                stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                @(negedge i_clk);
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (rsp_ch.valid !== 1'b1) @(posedge i_clk);
            got = '{rsp_ch.status, rsp_ch.grade_out, rsp_ch.position, rsp_ch.entry_count};
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with nothing outstanding, expected none, got %0h",
                         $time, got);
            end else begin
                want = awaited_results.pop_front();
                compare_field("status",      32'(want.status),      32'(got.status));
                compare_field("grade_out",   32'(want.grade_out),   32'(got.grade_out));
                compare_field("position",    32'(want.position),    32'(got.position));
                compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                results_checked++;
                if (!$isunknown(got.status)) status_seen[got.status]++;
            end
        end
    end

    // Ends the run when no request or result has moved for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, awaited_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
